### design/bucketed_hash_table_defines.svh
// ----------------------------------------------------------------------------
// bucketed hash table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is high
`define BHT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bucketed hash table check failed");
// check that also holds around reset
`define BHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bucketed hash table check failed");
`else
`define BHT_ASSERT(lbl, clk, rst, prop)
`define BHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// field widths, operation and status codes, sequencer states and the digit
// cube table of the bucketed hash table
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ID_W     = 14;
  localparam int unsigned QTY_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BIDX_W   = 6;

  localparam int unsigned BUCKETS_DEF          = 40;
  localparam int unsigned SLOTS_PER_BUCKET_DEF = 3;

  localparam logic [QTY_W-1:0] QTY_MAX = QTY_W'(2000);
  localparam logic [ID_W-1:0]  ID_MOD  = ID_W'(10000);

  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 14-bit x
  localparam int unsigned      DIV10_MUL_W = 16;
  localparam logic [15:0]      DIV10_MUL   = 16'd52429;
  localparam int unsigned      DIV10_SHIFT = 19;
  localparam int unsigned      PROD_W      = ID_W + DIV10_MUL_W;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP       = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  // cubes of the ascii digit codes '0' .. '9'
  localparam int unsigned DIGIT_CUBE [10] = '{
    110592, 117649, 125000, 132651, 140608,
    148877, 157464, 166375, 175616, 185193
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIGIT,
    S_BASE,
    S_SCAN,
    S_LAST,
    S_ACT
  } bht_state_t;

endpackage

`default_nettype wire

### design/bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// Bucketed hash table of 4-digit item ids with quantities.
// Input channel s_*: one request per transfer, s_tuser carries the operation
// (lookup, insert, delete), s_tdata the id and the quantity to store.
// Output channel m_*: exactly one result per request, m_tuser carries the
// status, m_tdata the found quantity and the bucket index.
// A request is worked through by one sequencer: it folds the four decimal
// digits of the id into the bucket index (one digit a cycle through a shared
// divide-by-ten multiplier and a modulo accumulator), forms the bucket base
// address, reads the SLOTS_PER_BUCKET slots of the bucket in turn from the
// slot memory, does the last compare, and then writes and registers the
// result. A new request is taken only once the sequencer is back in idle, so
// requests do not overlap in the sequencer.
// s_tready is high only while idle. A finished result waits in the output
// register; a new request is still taken, but its write and result step
// holds until the receiver has taken the previous result.
// Reset clears all slot valid bits at once, so the table starts empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bucketed_hash_table_defines.svh"

module bucketed_hash_table #(
  parameter int unsigned BUCKETS          = bht_pkg::BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_id[13:0], quantity_in[24:14], zeros above
  input  logic [bht_pkg::FUNC_W-1:0] s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // quantity_out[10:0], bucket_index[16:11], zeros above
  output logic [bht_pkg::STATUS_W-1:0] m_tuser  // status[1:0]
);

  import bht_pkg::*;

  localparam int unsigned TOTAL = BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned ENT_W = ID_W + QTY_W;

  // digit cube folded modulo the bucket count, indexed by the digit value
  localparam int unsigned CUBE_MOD [16] = '{
    DIGIT_CUBE[0] % BUCKETS, DIGIT_CUBE[1] % BUCKETS,
    DIGIT_CUBE[2] % BUCKETS, DIGIT_CUBE[3] % BUCKETS,
    DIGIT_CUBE[4] % BUCKETS, DIGIT_CUBE[5] % BUCKETS,
    DIGIT_CUBE[6] % BUCKETS, DIGIT_CUBE[7] % BUCKETS,
    DIGIT_CUBE[8] % BUCKETS, DIGIT_CUBE[9] % BUCKETS,
    0, 0, 0, 0, 0, 0
  };

  bht_state_t state, state_next;

  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   id_r;
  logic [QTY_W-1:0]  qty_r;
  logic [ID_W-1:0]   v;
  logic [BW-1:0]     acc;
  logic [1:0]        dcnt;
  logic [AW-1:0]     addr;
  logic [SW-1:0]     cnt;

  logic              rd_live;
  logic              rd_valid;
  logic [AW-1:0]     rd_addr;
  logic [ENT_W-1:0]  rd_data;

  logic              hit_found;
  logic [AW-1:0]     hit_addr;
  logic [QTY_W-1:0]  hit_qty;
  logic              free_found;
  logic [AW-1:0]     free_addr;

  logic [TOTAL-1:0]  valid;
  logic [ENT_W-1:0]  mem [TOTAL];

  logic [STATUS_W-1:0] out_status;
  logic [QTY_W-1:0]    out_qty;
  logic [BIDX_W-1:0]   out_bucket;

  // shared digit unit
  logic [ID_W-1:0]   in_id;
  logic [QTY_W-1:0]  in_qty;
  logic [PROD_W-1:0] prod;
  logic [ID_W-1:0]   quot;
  logic [ID_W-1:0]   rem;
  logic [3:0]        digit;
  logic [BW:0]       acc_sum;
  logic [BW-1:0]     acc_mod;
  logic [BW+BIDX_W-1:0] acc_ext;

  logic accept;
  logic act_go;
  logic mem_we;
  logic clr_hit;

  assign in_id  = s_tdata[ID_W-1:0];
  assign in_qty = s_tdata[ID_W+QTY_W-1:ID_W];

  assign prod    = PROD_W'(v) * PROD_W'(DIV10_MUL);
  assign quot    = ID_W'(prod >> DIV10_SHIFT);
  assign rem     = v - ((quot << 3) + (quot << 1));
  assign digit   = rem[3:0];
  assign acc_sum = (BW+1)'(acc) + (BW+1)'(CUBE_MOD[digit]);
  assign acc_mod = (acc_sum >= (BW+1)'(BUCKETS)) ? BW'(acc_sum - (BW+1)'(BUCKETS))
                                                  : BW'(acc_sum);
  assign acc_ext = {{BIDX_W{1'b0}}, acc};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    act_go     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept     = 1'b1;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (dcnt == 2'd3) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (cnt == SW'(SLOTS_PER_BUCKET - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_ACT;
      end
      S_ACT: begin
        if (!m_tvalid || m_tready) begin
          act_go     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mem_we  = act_go && (func_r == FUNC_INSERT) && !hit_found && free_found;
  assign clr_hit = (state == S_BASE);

  // request capture, digit folding and address stepping
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= s_tuser;
      id_r   <= in_id;
      qty_r  <= (in_qty > QTY_MAX) ? QTY_MAX : in_qty;
      // the hash only sees the four low decimal digits
      v      <= (in_id >= ID_MOD) ? in_id - ID_MOD : in_id;
      acc    <= '0;
      dcnt   <= '0;
    end
    if (state == S_DIGIT) begin
      v    <= quot;
      acc  <= acc_mod;
      dcnt <= dcnt + 2'd1;
    end
    if (state == S_BASE) begin
      addr <= AW'(acc * SLOTS_PER_BUCKET);
      cnt  <= '0;
    end
    if (state == S_SCAN) begin
      addr     <= addr + AW'(1);
      cnt      <= cnt + SW'(1);
      rd_addr  <= addr;
      rd_valid <= valid[addr];
    end
  end

  // slot compare on the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      rd_live <= (state == S_SCAN);
      if (clr_hit) begin
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (rd_live) begin
        if (rd_valid) begin
          if (!hit_found && rd_data[ENT_W-1:QTY_W] == id_r) begin
            hit_found <= 1'b1;
            hit_addr  <= rd_addr;
            hit_qty   <= rd_data[QTY_W-1:0];
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_addr  <= rd_addr;
        end
      end
    end
  end

  // slot memory, id and quantity
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_addr] <= {id_r, qty_r};
    end
    rd_data <= mem[addr];
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[free_addr] <= 1'b1;
    end else if (act_go && func_r == FUNC_DELETE && hit_found) begin
      valid[hit_addr] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (act_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act_go) begin
      out_bucket <= acc_ext[BIDX_W-1:0];
      out_qty    <= '0;
      if (func_r == FUNC_INSERT) begin
        if (hit_found) begin
          out_status <= STAT_DUP;
        end else if (!free_found) begin
          out_status <= STAT_FULL;
        end else begin
          out_status <= STAT_OK;
        end
      end else if (hit_found) begin
        out_status <= STAT_OK;
        out_qty    <= hit_qty;
      end else begin
        out_status <= STAT_NOT_FOUND;
      end
    end
  end

  assign m_tdata = {{(24 - QTY_W - BIDX_W){1'b0}}, out_bucket, out_qty};
  assign m_tuser = out_status;

  `BHT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE) && !m_tvalid)
  `BHT_ASSERT(a_acc_range, clk, rst, (state == S_BASE) |-> (acc < BUCKETS))
  `BHT_ASSERT(a_scan_in_store, clk, rst, (state == S_SCAN) |-> (addr < TOTAL))
  `BHT_ASSERT(a_hit_free_apart, clk, rst,
    (hit_found && free_found) |-> (hit_addr != free_addr))
  `BHT_ASSERT(a_dup_no_change, clk, rst,
    (act_go && func_r == FUNC_INSERT && hit_found) |=> (valid == $past(valid)))

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// bucketed hash table testbench
// drives lookup, insert, delete and spare-code requests on s_* and checks each
// reply on the m_* stream against a cycle-free model of the slot table; both
// sides idle at random, with one long reply hold-off and drain pauses
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bht_pkg::*;

  localparam int unsigned NBUCKETS    = BUCKETS_DEF;
  localparam int unsigned NSLOTS      = SLOTS_PER_BUCKET_DEF;
  localparam int unsigned TABLE_DEPTH = NBUCKETS * NSLOTS;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned ID_POOL_SIZE = 160;
  localparam int unsigned RANDOM_REQS  = 1880;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [QTY_W-1:0]  qty;
    logic              drain;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    qty;
    logic [BIDX_W-1:0]   bucket;
  } reply_t;

  logic clk;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;  // item_id[13:0], quantity_in[24:14], zeros above
  logic [FUNC_W-1:0]   s_tuser = '0;  // func[1:0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;       // quantity_out[10:0], bucket_index[16:11], zeros above
  logic [STATUS_W-1:0] m_tuser;       // status[1:0]

  bucketed_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // model of the slot table
  logic            slot_used [TABLE_DEPTH];
  logic [ID_W-1:0] slot_key  [TABLE_DEPTH];
  logic [QTY_W-1:0] slot_qty [TABLE_DEPTH];

  request_t    pending_reqs[$];
  reply_t      replies_due[$];
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

  int unsigned mismatches   = 0;
  int unsigned reqs_taken   = 0;
  int unsigned reqs_sent    = 0;
  int unsigned replies_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          req_done     = 0;
  bit          reply_done   = 0;
  bit          hold_arm     = 0;
  bit          tx_steady    = 0;
  bit          rx_steady    = 0;
  logic        next_valid;
  request_t    cur_req;
  reply_t      got_reply;
  reply_t      want_reply;

  // bucket: sum of cubes of the ascii codes of the four low decimal digits, mod NBUCKETS
  function automatic logic [BIDX_W-1:0] bucket_of_id(input logic [ID_W-1:0] id);
    int unsigned v;
    int unsigned code;
    int unsigned total;
    v = id % 10000;
    total = 0;
    for (int k = 0; k < 4; k++) begin
      code = 48 + v % 10;
      v = v / 10;
      total += code * code * code;
    end
    return BIDX_W'(total % NBUCKETS);
  endfunction

  function automatic reply_t serve_request(input request_t rq);
    reply_t r;
    int unsigned base;
    int hit;
    int free_slot;
    r.bucket = bucket_of_id(rq.id);
    r.status = STAT_NOT_FOUND;
    r.qty = '0;
    base = r.bucket * NSLOTS;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < NSLOTS; s++) begin
      if (slot_used[base + s]) begin
        if (hit < 0 && slot_key[base + s] == rq.id) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (rq.func == FUNC_INSERT) begin
      if (hit >= 0) begin
        r.status = STAT_DUP;
      end else if (free_slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        slot_used[base + free_slot] = 1'b1;
        slot_key[base + free_slot] = rq.id;
        slot_qty[base + free_slot] = (rq.qty > QTY_MAX) ? QTY_MAX : rq.qty;
        r.status = STAT_OK;
      end
    end else if (hit >= 0) begin
      // lookup, delete and the spare code all report the stored quantity
      r.status = STAT_OK;
      r.qty = slot_qty[base + hit];
      if (rq.func == FUNC_DELETE) begin
        slot_used[base + hit] = 1'b0;
        slot_key[base + hit] = '0;
        slot_qty[base + hit] = '0;
      end
    end
    return r;
  endfunction

  task automatic add_req(input logic [FUNC_W-1:0] func, input int unsigned id,
                         input int unsigned qty, input bit drain);
    request_t rq;
    rq.func = func;
    rq.id = ID_W'(id);
    rq.qty = QTY_W'(qty);
    rq.drain = drain;
    pending_reqs.push_back(rq);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (req_done) begin
        req_done = 0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && replies_due.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {7'b0, cur_req.qty, cur_req.id};
          s_tuser <= cur_req.func;
          next_valid = 1'b1;
          if (reqs_sent % 100 == 0) tx_steady = ($urandom_range(0, 2) == 0);
          reqs_sent++;
          gap_left = tx_steady ? 0 : $urandom_range(0, 7);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // reply side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (reply_done) begin
        reply_done = 0;
        if (replies_seen % 100 == 0) rx_steady = ($urandom_range(0, 2) == 0);
        stall_left = rx_steady ? 0 : $urandom_range(0, 7);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // long reply hold-off, so the block fills up and drops s_tready
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_arm = 0;
      hold_left <= HOLD_CYCLES;
    end
  end

  // transfer monitor and reply check
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        cur_req.func = s_tuser;
        cur_req.id = s_tdata[13:0];
        cur_req.qty = s_tdata[24:14];
        cur_req.drain = 1'b0;
        replies_due.push_back(serve_request(cur_req));
        req_done = 1;
        reqs_taken++;
        if (reqs_taken == 500) hold_arm = 1;
      end
      if (m_tvalid && m_tready) begin
        got_reply.status = m_tuser;
        got_reply.qty = m_tdata[10:0];
        got_reply.bucket = m_tdata[16:11];
        reply_done = 1;
        replies_seen++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("reply %0d with none outstanding: status %0d qty %0d bucket %0d",
                     replies_seen, got_reply.status, got_reply.qty, got_reply.bucket);
        end else begin
          want_reply = replies_due.pop_front();
          if (got_reply !== want_reply) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("reply %0d: expected status %0d qty %0d bucket %0d, got %0d %0d %0d",
                       replies_seen, want_reply.status, want_reply.qty, want_reply.bucket,
                       got_reply.status, got_reply.qty, got_reply.bucket);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bucketed_hash_table] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [FUNC_W-1:0] func;
    int unsigned id;
    int unsigned qty;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_qty[i] = '0;
    end
    for (int i = 0; i < ID_POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(0, 16383));

    // empty slots must not match id 0
    add_req(FUNC_LOOKUP, 0, 0, 0);
    add_req(FUNC_DELETE, 9999, 0, 0);
    add_req(FUNC_INSERT, 0, 0, 0);
    add_req(FUNC_LOOKUP, 0, 0, 0);
    add_req(FUNC_INSERT, 0, 5, 0);
    // ids above 9999 hash on the low four digits but compare all bits
    add_req(FUNC_INSERT, 10000, 1, 0);
    add_req(FUNC_INSERT, 9999, 2047, 0);
    add_req(FUNC_LOOKUP, 9999, 0, 0);
    add_req(FUNC_SPARE, 9999, 77, 0);
    add_req(FUNC_INSERT, 16383, 682, 0);
    add_req(FUNC_LOOKUP, 16383, 0, 0);
    add_req(FUNC_LOOKUP, 6383, 0, 0);
    // digit permutations share a bucket: fill it, overflow, then reuse a hole
    add_req(FUNC_INSERT, 1, 100, 0);
    add_req(FUNC_INSERT, 10, 200, 0);
    add_req(FUNC_INSERT, 100, 300, 0);
    add_req(FUNC_INSERT, 1000, 400, 0);
    add_req(FUNC_DELETE, 10, 0, 0);
    add_req(FUNC_INSERT, 1000, 1365, 0);
    add_req(FUNC_LOOKUP, 1000, 0, 0);
    add_req(FUNC_DELETE, 0, 0, 0);
    add_req(FUNC_DELETE, 0, 0, 0);
    add_req(FUNC_LOOKUP, 10000, 0, 0);
    add_req(FUNC_DELETE, 16383, 0, 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) func = FUNC_INSERT;
      else if (pick < 65) func = FUNC_LOOKUP;
      else if (pick < 95) func = FUNC_DELETE;
      else func = FUNC_SPARE;
      // mostly a small id pool so buckets fill, hit and overflow
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                       : id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
      qty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 2000);
      add_req(func, id, qty, (i == 0) || (i == 900));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (NSLOTS + 20) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("[bucketed_hash_table] OK");
    end else begin
      $display("[bucketed_hash_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
